/* src/tbfs_pkg.sv */
package tbfs_pkg;

   localparam int unsigned DOT_W  = 9;
   localparam int unsigned VADR_W = 15;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned BUS_W  = 14;
   localparam int unsigned COL_W  = 4;
   localparam int unsigned PAT_W  = 16;
   localparam int unsigned ATS_W  = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_TABLE_HIGH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_LEFT_EIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_X             = 2'd2;

   // fetch sequence, by dot modulo 8
   localparam logic [2:0] PH_PAT_HIGH  = 3'd0;
   localparam logic [2:0] PH_NAME_ADDR = 3'd1;
   localparam logic [2:0] PH_NAME_DATA = 3'd2;
   localparam logic [2:0] PH_ATTR_ADDR = 3'd3;
   localparam logic [2:0] PH_ATTR_DATA = 3'd4;
   localparam logic [2:0] PH_PAT_ADDR  = 3'd5;
   localparam logic [2:0] PH_PAT_LOW   = 3'd6;
   localparam logic [2:0] PH_PAT_HADDR = 3'd7;

   localparam logic [BUS_W-1:0] NAME_BASE     = 14'h2000;
   localparam logic [BUS_W-1:0] ATTR_KEEP     = 14'h2C00;
   localparam logic [BUS_W-1:0] ATTR_OFFSET   = 14'h03C0;
   localparam logic [BUS_W-1:0] PAT_HIGH_BASE = 14'h1000;
   localparam logic [BUS_W-1:0] PAT_PLANE_STEP = 14'h0008;
   localparam logic [DOT_W-1:0] LEFT_EDGE     = 9'd9;

   typedef struct packed {
      logic [DOT_W-1:0]  dot;
      logic [VADR_W-1:0] vram_addr;
      logic [BYTE_W-1:0] read_data;
      logic              fetch_en;
      logic              draw_en;
      logic              shift_en;
   } req_type;

   typedef struct packed {
      logic [BUS_W-1:0] mem_addr;
      logic             coarse_x_step;
      logic             pixel_valid;
      logic [COL_W-1:0] pixel_color;
      logic             bg_opaque;
   } rsp_type;

endpackage

/* src/tile_background_fetch_shifter.sv */
// channel   direction  handshake               payload
// req_      in         req_valid / req_ready   tbfs_pkg::req_type (one dot)
// rsp_      out        rsp_valid / rsp_ready   tbfs_pkg::rsp_type (one result per dot)
// csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// one dot per clock while req_ready is high: fetch, draw and shift are done in the accepting cycle
// and the result is captured in the output register rsp_ff
// req_ready drops only while the output register is full and rsp_ready is low
// reset (synchronous) clears the fetch latches, shifters and output valid,
// and loads the configuration defaults; csr_ready is always high
module tile_background_fetch_shifter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  tbfs_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tbfs_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tbfs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tbfs_pkg::CSR_DATA_W-1:0]       csr_data
);
   import tbfs_pkg::*;

   logic             pat_table_high_ff;
   logic             show_left_ff;
   logic [2:0]       fine_x_ff;

   logic [BUS_W-1:0]  bus_ff, bus_in;
   logic [BYTE_W-1:0] tile_ff, tile_in;
   logic [1:0]        attr_ff, attr_in;
   logic [BYTE_W-1:0] pat_lo_ff, pat_lo_in;
   logic [BYTE_W-1:0] pat_hi_ff, pat_hi_in;
   logic [PAT_W-1:0]  pat_lo_sh_ff, pat_lo_sh_in;
   logic [PAT_W-1:0]  pat_hi_sh_ff, pat_hi_sh_in;
   logic [ATS_W-1:0]  at_lo_sh_ff, at_lo_sh_in;
   logic [ATS_W-1:0]  at_hi_sh_ff, at_hi_sh_in;
   logic              at_lo_feed_ff, at_lo_feed_in;
   logic              at_hi_feed_ff, at_hi_feed_in;

   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   logic              req_accept;
   logic [2:0]        phase;
   logic [VADR_W-1:0] v;
   logic [1:0]        quad;
   logic [2:0]        tap;
   logic [1:0]        pat_bits;
   logic [1:0]        att_bits;
   logic              blank_left;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign phase = req_data.dot[2:0];
   assign v     = req_data.vram_addr;
   assign quad  = {v[6], v[1]};

   // fetch phase
   always_comb begin
      bus_in    = bus_ff;
      tile_in   = tile_ff;
      attr_in   = attr_ff;
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      if (req_data.fetch_en) begin
         case (phase)
            PH_NAME_ADDR: bus_in = NAME_BASE | {2'b00, v[11:0]};
            PH_NAME_DATA: tile_in = req_data.read_data;
            PH_ATTR_ADDR: bus_in = (bus_ff & ATTR_KEEP) + ATTR_OFFSET
                                   + {8'd0, v[9:7], 3'd0} + {11'd0, v[4:2]};
            PH_ATTR_DATA: attr_in = req_data.read_data[{quad, 1'b0} +: 2];
            PH_PAT_ADDR:  bus_in = (pat_table_high_ff ? PAT_HIGH_BASE : '0)
                                   | {2'b00, tile_ff, 1'b0, v[14:12]};
            PH_PAT_LOW:   pat_lo_in = req_data.read_data;
            PH_PAT_HADDR: bus_in = bus_ff + PAT_PLANE_STEP;
            PH_PAT_HIGH:  pat_hi_in = req_data.read_data;
            default:      bus_in = bus_ff;
         endcase
      end
   end

   // draw phase taps the shifters before they move
   always_comb begin
      tap        = 3'd7 - fine_x_ff;
      pat_bits   = {pat_hi_sh_ff[{1'b1, tap}], pat_lo_sh_ff[{1'b1, tap}]};
      att_bits   = {at_hi_sh_ff[tap], at_lo_sh_ff[tap]};
      blank_left = (req_data.dot < LEFT_EDGE) && !show_left_ff;

      rsp_in.mem_addr      = bus_in;
      rsp_in.coarse_x_step = req_data.fetch_en && (phase == PH_PAT_HIGH);
      rsp_in.pixel_valid   = req_data.draw_en;
      rsp_in.pixel_color   = '0;
      rsp_in.bg_opaque     = 1'b0;
      if (req_data.draw_en && !blank_left) begin
         rsp_in.pixel_color = {att_bits, pat_bits};
         rsp_in.bg_opaque   = |pat_bits;
      end
   end

   // shift phase, reload uses latches as left by the fetch phase
   always_comb begin
      pat_lo_sh_in  = pat_lo_sh_ff;
      pat_hi_sh_in  = pat_hi_sh_ff;
      at_lo_sh_in   = at_lo_sh_ff;
      at_hi_sh_in   = at_hi_sh_ff;
      at_lo_feed_in = at_lo_feed_ff;
      at_hi_feed_in = at_hi_feed_ff;
      if (req_data.shift_en) begin
         pat_lo_sh_in = {pat_lo_sh_ff[PAT_W-2:0], 1'b0};
         pat_hi_sh_in = {pat_hi_sh_ff[PAT_W-2:0], 1'b0};
         at_lo_sh_in  = {at_lo_sh_ff[ATS_W-2:0], at_lo_feed_ff};
         at_hi_sh_in  = {at_hi_sh_ff[ATS_W-2:0], at_hi_feed_ff};
         if (phase == PH_PAT_HIGH) begin
            pat_lo_sh_in  = {pat_lo_sh_ff[PAT_W-2:BYTE_W-1], pat_lo_in};
            pat_hi_sh_in  = {pat_hi_sh_ff[PAT_W-2:BYTE_W-1], pat_hi_in};
            at_lo_feed_in = attr_in[0];
            at_hi_feed_in = attr_in[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_table_high_ff <= 1'b0;
         show_left_ff      <= 1'b1;
         fine_x_ff         <= 3'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_TABLE_HIGH: pat_table_high_ff <= csr_data[0];
            CSR_SHOW_LEFT_EIGHT:    show_left_ff      <= csr_data[0];
            CSR_FINE_X:             fine_x_ff         <= csr_data[2:0];
            default:                ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff        <= '0;
         tile_ff       <= '0;
         attr_ff       <= '0;
         pat_lo_ff     <= '0;
         pat_hi_ff     <= '0;
         pat_lo_sh_ff  <= '0;
         pat_hi_sh_ff  <= '0;
         at_lo_sh_ff   <= '0;
         at_hi_sh_ff   <= '0;
         at_lo_feed_ff <= 1'b0;
         at_hi_feed_ff <= 1'b0;
      end else if (req_accept) begin
         bus_ff        <= bus_in;
         tile_ff       <= tile_in;
         attr_ff       <= attr_in;
         pat_lo_ff     <= pat_lo_in;
         pat_hi_ff     <= pat_hi_in;
         pat_lo_sh_ff  <= pat_lo_sh_in;
         pat_hi_sh_ff  <= pat_hi_sh_in;
         at_lo_sh_ff   <= at_lo_sh_in;
         at_hi_sh_ff   <= at_hi_sh_in;
         at_lo_feed_ff <= at_lo_feed_in;
         at_hi_feed_ff <= at_hi_feed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // every accepted request shows up as a result on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff
         && rsp_ff.coarse_x_step == $past(req_data.fetch_en && phase == PH_PAT_HIGH))
      else $error("result missing or wrong coarse x increment");

   a_opaque_drawn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.bg_opaque == (rsp_ff.pixel_valid
         && rsp_ff.pixel_color[1:0] != 2'b00))
      else $error("opaque flag disagrees with pattern bits");

   a_blank_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.pixel_valid |-> rsp_ff.pixel_color == '0)
      else $error("color set on an undrawn dot");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(pat_lo_sh_ff) && $stable(bus_ff) && $stable(attr_ff))
      else $error("fetch state moved without a request");

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   import tbfs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_TAIL  = 4;
   localparam int unsigned IDLE_PCT    = 35;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   tile_background_fetch_shifter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // predicted block state
   logic             cfg_pat_high  = 1'b0;
   logic             cfg_show_left = 1'b1;
   logic [2:0]       cfg_fine_x    = 3'd0;
   logic [BUS_W-1:0] bus_q         = '0;
   logic [7:0]       tile_q        = '0;
   logic [1:0]       attr_q        = '0;
   logic [7:0]       pat_lo_q      = '0;
   logic [7:0]       pat_hi_q      = '0;
   logic [15:0]      pat_lo_sh     = '0;
   logic [15:0]      pat_hi_sh     = '0;
   logic [7:0]       attr_lo_sh    = '0;
   logic [7:0]       attr_hi_sh    = '0;
   logic             attr_lo_feed  = 1'b0;
   logic             attr_hi_feed  = 1'b0;

   rsp_type     due_results[$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   logic        calm        = 1'b0;

   function automatic rsp_type compute_dot_result(input req_type d);
      rsp_type    r;
      logic [2:0] tap;
      logic [1:0] quad;
      logic [1:0] pat;
      r = '0;
      if (d.fetch_en) begin
         case (d.dot[2:0])
            PH_NAME_ADDR: bus_q = NAME_BASE | BUS_W'(d.vram_addr[11:0]);
            PH_NAME_DATA: tile_q = d.read_data;
            PH_ATTR_ADDR: bus_q = (bus_q & ATTR_KEEP) + ATTR_OFFSET
                                  + BUS_W'({d.vram_addr[9:7], 3'b000})
                                  + BUS_W'(d.vram_addr[4:2]);
            PH_ATTR_DATA: begin
               quad   = {d.vram_addr[6], d.vram_addr[1]};
               attr_q = 2'(d.read_data >> {quad, 1'b0});
            end
            PH_PAT_ADDR: bus_q = (cfg_pat_high ? PAT_HIGH_BASE : BUS_W'(0))
                                 | {2'b00, tile_q, 1'b0, d.vram_addr[14:12]};
            PH_PAT_LOW: pat_lo_q = d.read_data;
            PH_PAT_HADDR: bus_q = bus_q + PAT_PLANE_STEP;
            PH_PAT_HIGH: begin
               pat_hi_q        = d.read_data;
               r.coarse_x_step = 1'b1;
            end
            default: ;
         endcase
      end

      if (d.draw_en) begin
         r.pixel_valid = 1'b1;
         // leftmost dots blank out when the left column is hidden
         if (!(d.dot < LEFT_EDGE && !cfg_show_left)) begin
            tap           = 3'd7 - cfg_fine_x;
            pat           = {pat_hi_sh[8 + tap], pat_lo_sh[8 + tap]};
            r.pixel_color = {attr_hi_sh[tap], attr_lo_sh[tap], pat};
            r.bg_opaque   = (pat != 2'b00);
         end
      end

      if (d.shift_en) begin
         pat_lo_sh  = pat_lo_sh << 1;
         pat_hi_sh  = pat_hi_sh << 1;
         attr_lo_sh = {attr_lo_sh[6:0], attr_lo_feed};
         attr_hi_sh = {attr_hi_sh[6:0], attr_hi_feed};
         if (d.dot[2:0] == PH_PAT_HIGH) begin
            pat_lo_sh[7:0] = pat_lo_q;
            pat_hi_sh[7:0] = pat_hi_q;
            attr_lo_feed   = attr_q[0];
            attr_hi_feed   = attr_q[1];
         end
      end

      r.mem_addr = bus_q;
      return r;
   endfunction

   function automatic req_type make_dot(input logic [8:0] dot, input logic [14:0] vaddr,
                                        input logic [7:0] rd, input logic f,
                                        input logic dr, input logic s);
      req_type d;
      d.dot       = dot;
      d.vram_addr = vaddr;
      d.read_data = rd;
      d.fetch_en  = f;
      d.draw_en   = dr;
      d.shift_en  = s;
      return d;
   endfunction

   // valid stays high across back-to-back requests; only an idle gap or settle() lowers it
   task automatic send_dot(input req_type d);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      due_results.push_back(compute_dot_result(d));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // writes all three registers back to back; upper data bits are junk on purpose
   task automatic set_config(input logic pth, input logic sle, input logic [2:0] fx);
      logic [31:0] junk;
      junk      = $urandom;
      csr_valid <= 1'b1;
      csr_index <= CSR_PATTERN_TABLE_HIGH;
      csr_data  <= {junk[6:0], pth};
      do @(posedge clock); while (!csr_ready);
      cfg_pat_high = pth;
      csr_index <= CSR_SHOW_LEFT_EIGHT;
      csr_data  <= {junk[13:7], sle};
      do @(posedge clock); while (!csr_ready);
      cfg_show_left = sle;
      csr_index <= CSR_FINE_X;
      csr_data  <= {junk[20:16], fx};
      do @(posedge clock); while (!csr_ready);
      cfg_fine_x = fx;
      csr_valid <= 1'b0;
   endtask

   // mostly runs of consecutive dots, with some fully random requests mixed in
   task automatic run_scanlines(input int n_items);
      int          sent;
      int          seg_len;
      logic [8:0]  dot;
      logic [14:0] vaddr;
      req_type     d;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 15) begin
            d = make_dot(9'($urandom), 15'($urandom), 8'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom));
            send_dot(d);
            sent++;
         end else begin
            dot     = 9'($urandom_range(0, 340));
            vaddr   = 15'($urandom);
            seg_len = $urandom_range(8, 48);
            for (int k = 0; k < seg_len && sent < n_items; k++) begin
               d = make_dot(dot, vaddr, 8'($urandom),
                            $urandom_range(99) >= 4, $urandom_range(99) >= 8,
                            $urandom_range(99) >= 4);
               send_dot(d);
               sent++;
               if (d.fetch_en && dot[2:0] == PH_PAT_HIGH) vaddr[4:0] = vaddr[4:0] + 5'd1;
               if ($urandom_range(99) < 3) vaddr = 15'($urandom);
               dot = (dot == 9'd340) ? 9'd0 : dot + 9'd1;
            end
         end
      end
   endtask

   task automatic test_reset_state();
      send_dot(make_dot(9'd0, 15'h0000, 8'h00, 1'b0, 1'b0, 1'b0));
      send_dot(make_dot(9'd511, 15'h7FFF, 8'hFF, 1'b0, 1'b1, 1'b1));
   endtask

   task automatic test_tile_fetch();
      settle();
      set_config(1'b1, 1'b0, 3'd7);
      // two full tiles: name, attribute, pattern low and high
      for (int n = 1; n <= 16; n++) begin
         send_dot(make_dot(9'(n), (n <= 8) ? 15'h7FFF : 15'h0042,
                           n[0] ? 8'hFF : 8'h5A, 1'b1, 1'b1, 1'b1));
      end
      send_dot(make_dot(9'd8, 15'h0000, 8'h00, 1'b0, 1'b1, 1'b1));
      send_dot(make_dot(9'd9, 15'h0000, 8'h00, 1'b0, 1'b1, 1'b1));
      send_dot(make_dot(9'd340, 15'h7FFF, 8'hFF, 1'b1, 1'b1, 1'b0));
      send_dot(make_dot(9'd504, 15'h2AAA, 8'hC3, 1'b1, 1'b0, 1'b1));
   endtask

   task automatic test_random_scanlines();
      settle();
      set_config(1'b0, 1'b1, 3'd0);
      run_scanlines(250);
      settle();
      set_config(1'b1, 1'b0, 3'd7);
      run_scanlines(250);
      settle();
      set_config(1'($urandom), 1'($urandom), 3'($urandom));
      run_scanlines(200);
   endtask

   task automatic test_no_stall_stretch();
      settle();
      set_config(1'($urandom), 1'($urandom), 3'($urandom));
      calm = 1'b1;
      run_scanlines(250);
      calm = 1'b0;
   endtask

   task automatic test_sender_pause();
      settle();
      set_config(1'b1, 1'b1, 3'($urandom_range(1, 6)));
      run_scanlines(150);
      settle();
      run_scanlines(150);
      settle();
      set_config(1'($urandom), 1'b0, 3'($urandom));
      run_scanlines(150);
   endtask

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("unexpected result: mem_addr %h", rsp_data.mem_addr);
            mismatches++;
         end else begin
            rsp_type want;
            want = due_results.pop_front();
            if (rsp_data.mem_addr !== want.mem_addr) begin
               $error("mem_addr: expected %h, actual %h", want.mem_addr, rsp_data.mem_addr);
               mismatches++;
            end
            if (rsp_data.coarse_x_step !== want.coarse_x_step) begin
               $error("coarse_x_step: expected %b, actual %b",
                      want.coarse_x_step, rsp_data.coarse_x_step);
               mismatches++;
            end
            if (rsp_data.pixel_valid !== want.pixel_valid) begin
               $error("pixel_valid: expected %b, actual %b",
                      want.pixel_valid, rsp_data.pixel_valid);
               mismatches++;
            end
            if (rsp_data.pixel_color !== want.pixel_color) begin
               $error("pixel_color: expected %h, actual %h",
                      want.pixel_color, rsp_data.pixel_color);
               mismatches++;
            end
            if (rsp_data.bg_opaque !== want.bg_opaque) begin
               $error("bg_opaque: expected %b, actual %b", want.bg_opaque, rsp_data.bg_opaque);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_tile_fetch();
      test_random_scanlines();
      test_no_stall_stretch();
      test_sender_pause();
      settle();
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
